/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression is never true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

/* src/efmfd_pkg.sv */
// ----------------------------------------------------------------------------
// EFM frame decoder package
// Types, constants and the EFM code table shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efmfd_pkg;

  localparam int WIN_W     = 14;
  localparam int CNT_W     = 12;
  localparam int SUB_POS   = 40;
  localparam int FIRST_SYM = 57;
  localparam int SYM_STEP  = 17;

  localparam logic [1:0] KIND_S0  = 2'd0;
  localparam logic [1:0] KIND_S1  = 2'd1;
  localparam logic [1:0] KIND_SUB = 2'd2;

  localparam logic [1:0] LEN_EQUAL = 2'd0;
  localparam logic [1:0] LEN_SHORT = 2'd1;
  localparam logic [1:0] LEN_LONG  = 2'd2;

  localparam logic [13:0] SYNC0_PAT = 14'b00100000000001;
  localparam logic [13:0] SYNC1_PAT = 14'b00000000010010;

  // Position of the back end within one queued entry.
  typedef enum logic [2:0] {
    PH_EV0,
    PH_EV1,
    PH_MISS,
    PH_LAST,
    PH_NONE
  } efmfd_phase_t;

  // One accepted run length, classified by the front end.
  typedef struct packed {
    logic              ev0;
    logic [4:0]        k0;
    logic [WIN_W-1:0]  w0;
    logic              ev1;
    logic [4:0]        k1;
    logic [WIN_W-1:0]  w1;
    logic              fe;
    logic [5:0]        sdone;
    logic [CNT_W-1:0]  count;
    logic [1:0]        kind;
    logic [7:0]        sub;
    logic              bad;
    logic              hval;
    logic [WIN_W-1:0]  hwin;
  } efmfd_entry_t;

  localparam logic [13:0] EFM_CODE [256] = '{
    14'b01001000100000, 14'b10000100000000, 14'b10010000100000, 14'b10001000100000,
    14'b01000100000000, 14'b00000100010000, 14'b00010000100000, 14'b00100100000000,
    14'b01001001000000, 14'b10000001000000, 14'b10010001000000, 14'b10001001000000,
    14'b01000001000000, 14'b00000001000000, 14'b00010001000000, 14'b00100001000000,
    14'b10000000100000, 14'b10000010000000, 14'b10010010000000, 14'b00100000100000,
    14'b01000010000000, 14'b00000010000000, 14'b00010010000000, 14'b00100010000000,
    14'b01001000010000, 14'b10000000010000, 14'b10010000010000, 14'b10001000010000,
    14'b01000000010000, 14'b00001000010000, 14'b00010000010000, 14'b00100000010000,
    14'b00000000100000, 14'b10000100001000, 14'b00001000100000, 14'b00100100100000,
    14'b01000100001000, 14'b00000100001000, 14'b01000000100000, 14'b00100100001000,
    14'b01001001001000, 14'b10000001001000, 14'b10010001001000, 14'b10001001001000,
    14'b01000001001000, 14'b00000001001000, 14'b00010001001000, 14'b00100001001000,
    14'b00000100000000, 14'b10000010001000, 14'b10010010001000, 14'b10000100010000,
    14'b01000010001000, 14'b00000010001000, 14'b00010010001000, 14'b00100010001000,
    14'b01001000001000, 14'b10000000001000, 14'b10010000001000, 14'b10001000001000,
    14'b01000000001000, 14'b00001000001000, 14'b00010000001000, 14'b00100000001000,
    14'b01001000100100, 14'b10000100100100, 14'b10010000100100, 14'b10001000100100,
    14'b01000100100100, 14'b00000000100100, 14'b00010000100100, 14'b00100100100100,
    14'b01001001000100, 14'b10000001000100, 14'b10010001000100, 14'b10001001000100,
    14'b01000001000100, 14'b00000001000100, 14'b00010001000100, 14'b00100001000100,
    14'b10000000100100, 14'b10000010000100, 14'b10010010000100, 14'b00100000100100,
    14'b01000010000100, 14'b00000010000100, 14'b00010010000100, 14'b00100010000100,
    14'b01001000000100, 14'b10000000000100, 14'b10010000000100, 14'b10001000000100,
    14'b01000000000100, 14'b00001000000100, 14'b00010000000100, 14'b00100000000100,
    14'b01001000100010, 14'b10000100100010, 14'b10010000100010, 14'b10001000100010,
    14'b01000100100010, 14'b00000000100010, 14'b01000000100100, 14'b00100100100010,
    14'b01001001000010, 14'b10000001000010, 14'b10010001000010, 14'b10001001000010,
    14'b01000001000010, 14'b00000001000010, 14'b00010001000010, 14'b00100001000010,
    14'b10000000100010, 14'b10000010000010, 14'b10010010000010, 14'b00100000100010,
    14'b01000010000010, 14'b00000010000010, 14'b00010010000010, 14'b00100010000010,
    14'b01001000000010, 14'b00001001001000, 14'b10010000000010, 14'b10001000000010,
    14'b01000000000010, 14'b00001000000010, 14'b00010000000010, 14'b00100000000010,
    14'b01001000100001, 14'b10000100100001, 14'b10010000100001, 14'b10001000100001,
    14'b01000100100001, 14'b00000000100001, 14'b00010000100001, 14'b00100100100001,
    14'b01001001000001, 14'b10000001000001, 14'b10010001000001, 14'b10001001000001,
    14'b01000001000001, 14'b00000001000001, 14'b00010001000001, 14'b00100001000001,
    14'b10000000100001, 14'b10000010000001, 14'b10010010000001, 14'b00100000100001,
    14'b01000010000001, 14'b00000010000001, 14'b00010010000001, 14'b00100010000001,
    14'b01001000000001, 14'b10000010010000, 14'b10010000000001, 14'b10001000000001,
    14'b01000010010000, 14'b00001000000001, 14'b00010000000001, 14'b00100010010000,
    14'b00001000100001, 14'b10000100001001, 14'b01000100010000, 14'b00000100100001,
    14'b01000100001001, 14'b00000100001001, 14'b01000000100001, 14'b00100100001001,
    14'b01001001001001, 14'b10000001001001, 14'b10010001001001, 14'b10001001001001,
    14'b01000001001001, 14'b00000001001001, 14'b00010001001001, 14'b00100001001001,
    14'b00000100100000, 14'b10000010001001, 14'b10010010001001, 14'b00100100010000,
    14'b01000010001001, 14'b00000010001001, 14'b00010010001001, 14'b00100010001001,
    14'b01001000001001, 14'b10000000001001, 14'b10010000001001, 14'b10001000001001,
    14'b01000000001001, 14'b00001000001001, 14'b00010000001001, 14'b00100000001001,
    14'b01000100100000, 14'b10000100010001, 14'b10010010010000, 14'b00001000100100,
    14'b01000100010001, 14'b00000100010001, 14'b00010010010000, 14'b00100100010001,
    14'b00001001000001, 14'b10000100000001, 14'b00001001000100, 14'b00001001000000,
    14'b01000100000001, 14'b00000100000001, 14'b00000010010000, 14'b00100100000001,
    14'b00000100100100, 14'b10000010010001, 14'b10010010010001, 14'b10000100100000,
    14'b01000010010001, 14'b00000010010001, 14'b00010010010001, 14'b00100010010001,
    14'b01001000010001, 14'b10000000010001, 14'b10010000010001, 14'b10001000010001,
    14'b01000000010001, 14'b00001000010001, 14'b00010000010001, 14'b00100000010001,
    14'b01000100000010, 14'b00000100000010, 14'b10000100010010, 14'b00100100000010,
    14'b01000100010010, 14'b00000100010010, 14'b01000000100010, 14'b00100100010010,
    14'b10000100000010, 14'b10000100000100, 14'b00001001001001, 14'b00001001000010,
    14'b01000100000100, 14'b00000100000100, 14'b00010000100010, 14'b00100100000100,
    14'b00000100100010, 14'b10000010010010, 14'b10010010010010, 14'b00001000100010,
    14'b01000010010010, 14'b00000010010010, 14'b00010010010010, 14'b00100010010010,
    14'b01001000010010, 14'b10000000010010, 14'b10010000010010, 14'b10001000010010,
    14'b01000000010010, 14'b00001000010010, 14'b00010000010010, 14'b00100000010010
  };

  // Reverse table lookup: bit 8 set when the word is a data code.
  function automatic logic [8:0] efm_lookup(input logic [13:0] w);
    logic [8:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (EFM_CODE[i] == w) begin
        r = {1'b1, 8'(i)};
      end
    end
    return r;
  endfunction

  // Window after shifting in cnt channel bits; the first of them is a one when one is set.
  function automatic logic [13:0] efm_shift(input logic [13:0] w, input logic [4:0] cnt,
                                            input logic one);
    logic [31:0] x;
    x = 32'(w) << cnt;
    if (one && (cnt != 5'd0)) begin
      x = x | (32'd1 << (cnt - 5'd1));
    end
    return x[13:0];
  endfunction

endpackage

/* src/efmfd_front.sv */
// ----------------------------------------------------------------------------
// EFM frame decoder front end
// Expands run lengths, tracks frame position and classifies symbol events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efmfd_front #(
  parameter int SYMBOLS_PER_FRAME = 32,
  parameter int MAX_COUNT_BITS    = 1023
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [3:0]            t_value,
  input  logic                  frame_end,
  input  logic                  accept,
  output efmfd_pkg::efmfd_entry_t entry
);
  import efmfd_pkg::*;

  localparam int POS_W = $clog2(MAX_COUNT_BITS + 1);
  localparam logic [POS_W-1:0] MAXC = POS_W'(MAX_COUNT_BITS);
  localparam logic [5:0] SPF = 6'(SYMBOLS_PER_FRAME);

  logic [WIN_W-1:0] win, win_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] nsp, nsp_next;
  logic [5:0]       sdone, sdone_next;
  logic [1:0]       kind, kind_next;
  logic [7:0]       sub, sub_next;
  logic             bad, bad_next;
  logic             hval, hval_next;
  logic [WIN_W-1:0] hwin, hwin_next;

  logic [3:0]       tc, n_run;
  logic [2:0]       pad, n_pad;
  logic [4:0]       n, j0, js;
  logic [POS_W-1:0] rem_run, cnt, rem_pad, endp;
  logic             one, ev0, ev1, sev, last0, last1;
  logic [WIN_W-1:0] w0, w1, ws;
  logic [8:0]       sdec;

  // Run expansion and padding lengths.
  always_comb begin
    tc = (t_value < 4'd3) ? 4'd3 : ((t_value > 4'd11) ? 4'd11 : t_value);
    rem_run = MAXC - pos;
    n_run = (rem_run < POS_W'(tc)) ? rem_run[3:0] : tc;
    cnt = pos + POS_W'(n_run);
    rem_pad = MAXC - cnt;
    pad = 3'(3'd0 - cnt[2:0]);
    if (frame_end && (cnt < MAXC)) begin
      n_pad = (rem_pad < POS_W'(pad)) ? rem_pad[2:0] : pad;
    end else begin
      n_pad = 3'd0;
    end
    n = 5'(n_run) + 5'(n_pad);
    endp = pos + POS_W'(n);
    one = (n_run != 4'd0);
  end

  // Symbol and subcode window events within this item.
  always_comb begin
    ev0 = (sdone < SPF) && (nsp >= pos) && (nsp < endp);
    j0 = 5'(nsp - pos);
    ev1 = ev0 && ((sdone + 6'd1) < SPF) && ((6'(j0) + 6'(SYM_STEP)) < 6'(n));
    w0 = efm_shift(win, j0 + 5'd1, one);
    w1 = efm_shift(win, 5'(j0 + 5'(SYM_STEP) + 5'd1), one);
    last0 = ev0 && (sdone == SPF - 6'd1);
    last1 = ev1 && ((sdone + 6'd1) == SPF - 6'd1);
    sev = (pos <= POS_W'(SUB_POS)) && (endp > POS_W'(SUB_POS));
    js = 5'(POS_W'(SUB_POS) - pos);
    ws = efm_shift(win, js + 5'd1, one);
    sdec = efm_lookup(ws);
  end

  // Next state of the frame tracker.
  always_comb begin
    kind_next = kind;
    sub_next = sub;
    bad_next = bad;
    if (sev) begin
      if (ws == SYNC0_PAT) begin
        kind_next = KIND_S0;
        sub_next = 8'd0;
        bad_next = 1'b0;
      end else if (ws == SYNC1_PAT) begin
        kind_next = KIND_S1;
        sub_next = 8'd0;
        bad_next = 1'b0;
      end else begin
        kind_next = KIND_SUB;
        sub_next = sdec[8] ? sdec[7:0] : 8'd0;
        bad_next = !sdec[8];
      end
    end
    win_next = efm_shift(win, n, one);
    pos_next = endp;
    sdone_next = sdone + 6'(ev0) + 6'(ev1);
    nsp_next = nsp + (ev0 ? POS_W'(SYM_STEP) : '0) + (ev1 ? POS_W'(SYM_STEP) : '0);
    hval_next = hval | last0 | last1;
    hwin_next = last1 ? w1 : (last0 ? w0 : hwin);
  end

  // Classified entry for the queue.
  always_comb begin
    entry.ev0 = ev0 && !last0;
    entry.k0 = sdone[4:0];
    entry.w0 = w0;
    entry.ev1 = ev1 && !last1;
    entry.k1 = 5'(sdone + 6'd1);
    entry.w1 = w1;
    entry.fe = frame_end;
    entry.sdone = sdone_next;
    entry.count = CNT_W'(cnt);
    entry.kind = kind_next;
    entry.sub = sub_next;
    entry.bad = bad_next;
    entry.hval = hval_next;
    entry.hwin = hwin_next;
  end

  // Frame state; a frame end returns it to the start of a frame.
  always_ff @(posedge clk) begin
    if (rst || (accept && frame_end)) begin
      win <= '0;
      pos <= '0;
      nsp <= POS_W'(FIRST_SYM);
      sdone <= '0;
      kind <= KIND_SUB;
      sub <= '0;
      bad <= 1'b1;
      hval <= 1'b0;
      hwin <= '0;
    end else if (accept) begin
      win <= win_next;
      pos <= pos_next;
      nsp <= nsp_next;
      sdone <= sdone_next;
      kind <= kind_next;
      sub <= sub_next;
      bad <= bad_next;
      hval <= hval_next;
      hwin <= hwin_next;
    end
  end

endmodule

/* src/efmfd_queue.sv */
// ----------------------------------------------------------------------------
// EFM frame decoder queue
// Small register FIFO of classified entries between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module efmfd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  efmfd_pkg::efmfd_entry_t din,
  output logic                    full,
  input  logic                    pop,
  output logic                    empty,
  output efmfd_pkg::efmfd_entry_t dout
);
  import efmfd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  efmfd_entry_t      mem [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [AW:0]       count;

  assign full = (count == (AW + 1)'(DEPTH));
  assign empty = (count == '0);
  assign dout = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full, "queue written while full")
  `ASSERT_NEVER(a_no_underflow, pop && empty, "queue read while empty")
  `ASSERT_CLK(a_count_up, (push && !pop) |=> (count == $past(count) + 1'b1), "fill level lost")
endmodule

/* src/efmfd_back.sv */
// ----------------------------------------------------------------------------
// EFM frame decoder back end
// Walks each queued entry, decodes data symbols and drives the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efmfd_back #(
  parameter int SYMBOLS_PER_FRAME = 32,
  parameter int FRAME_BITS        = 588
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  efmfd_pkg::efmfd_entry_t e,
  output logic                    q_pop,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [39:0]             m_axis_tdata,
  output logic                    m_axis_tlast
);
  import efmfd_pkg::*;

  localparam logic [5:0] LAST_K = 6'(SYMBOLS_PER_FRAME - 1);

  efmfd_phase_t ph, ph_next, eff;
  logic [5:0]   mk, mk_next, kk;
  logic         can, emit, fin;
  logic [13:0]  dw;
  logic [8:0]   dd;
  logic [4:0]   o_idx;
  logic [7:0]   o_byte;
  logic         o_err;
  logic [1:0]   o_status;
  logic [9:0]   o_bits;

  // Pick the next result of the head entry and the phase after it.
  always_comb begin
    can = !m_axis_tvalid || m_axis_tready;
    kk = (ph == PH_MISS) ? mk : e.sdone;
    if (q_empty) begin
      eff = PH_NONE;
    end else if ((ph == PH_EV0) && e.ev0) begin
      eff = PH_EV0;
    end else if (((ph == PH_EV0) || (ph == PH_EV1)) && e.ev1) begin
      eff = PH_EV1;
    end else if ((ph != PH_LAST) && e.fe && (kk < LAST_K)) begin
      eff = PH_MISS;
    end else if (e.fe) begin
      eff = PH_LAST;
    end else begin
      eff = PH_NONE;
    end
    fin = (eff == PH_NONE) || (eff == PH_LAST) || ((eff == PH_EV1) && !e.fe) ||
          ((eff == PH_EV0) && !e.ev1 && !e.fe);
    emit = (eff != PH_NONE) && can;
    q_pop = !q_empty && fin && ((eff == PH_NONE) || can);
    ph_next = ph;
    mk_next = mk;
    if (q_pop) begin
      ph_next = PH_EV0;
    end else if (emit) begin
      case (eff)
        PH_EV0: ph_next = PH_EV1;
        PH_EV1: begin
          ph_next = PH_MISS;
          mk_next = e.sdone;
        end
        PH_MISS: begin
          ph_next = PH_MISS;
          mk_next = kk + 6'd1;
        end
        default: ph_next = ph;
      endcase
    end
  end

  // Symbol decode and result fields.
  always_comb begin
    case (eff)
      PH_EV0:  dw = e.w0;
      PH_EV1:  dw = e.w1;
      default: dw = e.hwin;
    endcase
    dd = efm_lookup(dw);
    o_status = LEN_EQUAL;
    o_bits = '0;
    case (eff)
      PH_EV0: begin
        o_idx = e.k0;
        o_byte = dd[7:0];
        o_err = !dd[8];
      end
      PH_EV1: begin
        o_idx = e.k1;
        o_byte = dd[7:0];
        o_err = !dd[8];
      end
      PH_LAST: begin
        o_idx = LAST_K[4:0];
        o_byte = (e.hval && dd[8]) ? dd[7:0] : 8'd0;
        o_err = !(e.hval && dd[8]);
        o_bits = e.count[9:0];
        if (e.count == CNT_W'(FRAME_BITS)) begin
          o_status = LEN_EQUAL;
        end else if (e.count < CNT_W'(FRAME_BITS)) begin
          o_status = LEN_SHORT;
        end else begin
          o_status = LEN_LONG;
        end
      end
      default: begin
        o_idx = kk[4:0];
        o_byte = 8'd0;
        o_err = 1'b1;
      end
    endcase
  end

  // Phase registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_EV0;
      mk <= '0;
    end else begin
      ph <= ph_next;
      mk <= mk_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (can) begin
      m_axis_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {3'd0, o_bits, o_status, e.bad, e.sub, e.kind, o_err, o_byte, o_idx};
      m_axis_tlast <= (eff == PH_LAST);
    end
  end

endmodule

/* src/efm_channel_frame_decoder.sv */
// ----------------------------------------------------------------------------
// EFM channel frame decoder
// Run lengths in, one decoded data symbol per result transfer out.
// ----------------------------------------------------------------------------
// A run length is taken every clock cycle while the queue is not full and is
// expanded combinationally (up to 11 channel bits plus up to 7 padding bits
// at frame end). The front end places each transfer in a four-entry queue;
// the back end emits one result per cycle from it while the output is ready,
// and a frame-end run yields up to SYMBOLS_PER_FRAME results at the output
// port, which sets the sustained rate when frames end short.
`timescale 1ns / 1ps

module efm_channel_frame_decoder #(
  parameter int SYMBOLS_PER_FRAME = 32,
  parameter int FRAME_BITS        = 588,
  parameter int MAX_COUNT_BITS    = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] t_value, [7:4] zero
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] symbol_index, [12:5] data_byte, [13] symbol_error, [15:14] frame_type,
  // [23:16] subcode_byte, [24] subcode_error, [26:25] length_status,
  // [36:27] frame_bits, [39:37] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast    // last
);
  import efmfd_pkg::*;

  efmfd_entry_t fe_entry, q_head;
  logic         accept, q_full, q_empty, q_pop;

  assign s_axis_tready = !q_full;
  assign accept = s_axis_tvalid && s_axis_tready;

  efmfd_front #(
    .SYMBOLS_PER_FRAME(SYMBOLS_PER_FRAME),
    .MAX_COUNT_BITS(MAX_COUNT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .t_value(s_axis_tdata[3:0]),
    .frame_end(s_axis_tlast),
    .accept(accept),
    .entry(fe_entry)
  );

  efmfd_queue #(
    .DEPTH(4)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(accept),
    .din(fe_entry),
    .full(q_full),
    .pop(q_pop),
    .empty(q_empty),
    .dout(q_head)
  );

  efmfd_back #(
    .SYMBOLS_PER_FRAME(SYMBOLS_PER_FRAME),
    .FRAME_BITS(FRAME_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .e(q_head),
    .q_pop(q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

endmodule
